// ===== hdl/kafq_pkg.sv =====
// shared types and constants for the keyframe aware frame queue
// used by kafq_cell and keyframe_aware_frame_queue; depends on nothing
package kafq_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int HANDLE_W      = 32;
  localparam int NUMBER_W      = 64;
  localparam int TIME_W        = 64;
  localparam int LIMIT_W       = 4;
  localparam int DISC_W        = 3;
  localparam int OCC_W         = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  // request kinds carried on s_tuser
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // one frame descriptor
  typedef struct packed {
    logic                key;
    logic [TIME_W-1:0]   ptime;
    logic [NUMBER_W-1:0] number;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_APPEND,
    ST_DROP,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/kafq_cell.sv =====
// one storage cell of the frame queue chain: holds a single descriptor
// depends on kafq_pkg
module kafq_cell (
  input  logic                clk,
  input  kafq_pkg::cell_ctrl_t ctrl,
  input  kafq_pkg::entry_t    new_entry,
  input  kafq_pkg::entry_t    next_entry,
  output kafq_pkg::entry_t    entry
);

  // load of a new descriptor wins over a shift from the neighbour
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= new_entry;
    end else if (ctrl.shift) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== hdl/keyframe_aware_frame_queue.sv =====
// keyframe aware frame queue: a chain of descriptor cells and its sequencer
// depends on kafq_pkg and kafq_cell
//
// usage
//   s_* takes requests: s_tuser 0 enqueues the descriptor in s_tdata,
//   s_tuser 1 dequeues (s_tdata ignored). every request gives exactly one
//   transaction on m_*, where m_tuser is 1 when a frame was delivered.
//   cfg_* writes queue_limit at any time the queue is idle; cfg_ready is
//   always high. a limit of 0 acts as 1, one above DEPTH acts as DEPTH.
// sequencing
//   enqueue below the limit: append, then finish into the output register.
//   enqueue at the limit: a serial scan of the key marks, one cell per
//   cycle, up to the oldest non-keyframe, then evict, append and finish.
//   dequeue: the drop state shifts the chain once per dropped entry and
//   once for the delivered one. the next request is accepted once the
//   sequencer is back in idle; at most one request is in flight.
// reset (rst, synchronous) empties the queue and sets the limit to 8.
// when the receiver stalls the result waits in the output register and
// the sequencer holds its finished request until the result is taken.
module keyframe_aware_frame_queue #(
  parameter int DEPTH = kafq_pkg::DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data,   // queue_limit
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [167:0] s_tdata,    // frame_handle[31:0], frame_number[95:32],
                                   // presentation_time[159:96], key_mark[160], zero pad
  input  logic         s_tuser,    // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,    // out_handle[31:0], out_number[95:32],
                                   // out_time[159:96], out_key[160], evicted[161],
                                   // discarded_count[164:162], occupancy[168:165], zero pad
  output logic         m_tuser     // frame_valid
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > kafq_pkg::LIMIT_W) ? CW : kafq_pkg::LIMIT_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  kafq_pkg::state_t state, state_next;

  logic [kafq_pkg::LIMIT_W-1:0] queue_limit;
  logic [CW-1:0]                count;
  logic [IW-1:0]                scan_idx;
  logic [IW-1:0]                victim;
  logic                         req_kind;
  kafq_pkg::entry_t             req_entry;

  kafq_pkg::entry_t             res_entry;
  logic                         res_valid;
  logic                         res_evicted;
  logic [kafq_pkg::DISC_W-1:0]  res_dropped;

  kafq_pkg::entry_t             out_entry;
  logic                         out_valid;
  logic                         out_evicted;
  logic [kafq_pkg::DISC_W-1:0]  out_dropped;
  logic [kafq_pkg::OCC_W-1:0]   out_occ;

  kafq_pkg::entry_t             cell_data [DEPTH];
  kafq_pkg::cell_ctrl_t         cell_ctrl [DEPTH];
  logic [DEPTH-1:0]             key_vec;

  // sequencer strobes
  logic          do_shift;
  logic [IW-1:0] shift_base;
  logic          do_append;
  logic          out_free;
  logic          drop_more;
  logic          scan_hit;
  logic          scan_last;
  logic [CW-1:0] limit_eff;
  logic [LW-1:0] limit_wide;
  logic [LW-1:0] count_wide;
  logic [kafq_pkg::OCC_W-1:0] occ_now;

  kafq_pkg::entry_t s_entry;

  assign s_entry.handle = s_tdata[31:0];
  assign s_entry.number = s_tdata[95:32];
  assign s_entry.ptime  = s_tdata[159:96];
  assign s_entry.key    = s_tdata[160];

  assign cfg_ready = 1'b1;

  // effective limit, clamped to 1..DEPTH
  assign limit_wide = LW'(queue_limit);
  always_comb begin
    if (queue_limit == '0) begin
      limit_eff = CW'(1);
    end else if (limit_wide > DEPTH_L) begin
      limit_eff = CW'(DEPTH);
    end else begin
      limit_eff = limit_wide[CW-1:0];
    end
  end

  assign count_wide = LW'(count);
  assign occ_now    = (count_wide > LW'(15)) ? 4'd15 : count_wide[kafq_pkg::OCC_W-1:0];

  assign scan_hit  = !key_vec[scan_idx];
  assign scan_last = (CW'(scan_idx) == count - CW'(1));
  assign drop_more = (count > CW'(1)) && !(key_vec[0] && !key_vec[1]);
  assign out_free  = !m_tvalid || m_tready;

  // the chain: each cell takes from its neighbour towards the tail
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      kafq_pkg::entry_t nb;
      if (gi == DEPTH - 1) begin : g_tail
        assign nb = '0;
      end else begin : g_body
        assign nb = cell_data[gi+1];
      end
      assign cell_ctrl[gi].shift = do_shift && (IW'(gi) >= shift_base);
      assign cell_ctrl[gi].load  = do_append && (count == CW'(gi));
      assign key_vec[gi]         = cell_data[gi].key;

      kafq_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[gi]),
        .new_entry  (req_entry),
        .next_entry (nb),
        .entry      (cell_data[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kafq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    do_shift   = 1'b0;
    shift_base = '0;
    do_append  = 1'b0;
    case (state)
      kafq_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == kafq_pkg::REQ_ENQUEUE) begin
            if (count >= limit_eff && count != '0) begin
              state_next = kafq_pkg::ST_SCAN;
            end else begin
              state_next = kafq_pkg::ST_APPEND;
            end
          end else if (count == '0) begin
            state_next = kafq_pkg::ST_FINISH;
          end else begin
            state_next = kafq_pkg::ST_DROP;
          end
        end
      end
      kafq_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = kafq_pkg::ST_EVICT;
        end
      end
      kafq_pkg::ST_EVICT: begin
        do_shift   = 1'b1;
        shift_base = victim;
        state_next = kafq_pkg::ST_APPEND;
      end
      kafq_pkg::ST_APPEND: begin
        do_append  = (count < CW'(DEPTH));
        state_next = kafq_pkg::ST_FINISH;
      end
      kafq_pkg::ST_DROP: begin
        do_shift = 1'b1;
        if (!drop_more) begin
          state_next = kafq_pkg::ST_FINISH;
        end
      end
      kafq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = kafq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kafq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= kafq_pkg::LIMIT_RESET;
      count       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        queue_limit <= cfg_data;
      end
      if (state == kafq_pkg::ST_EVICT || state == kafq_pkg::ST_DROP) begin
        count <= count - CW'(1);
      end else if (do_append) begin
        count <= count + CW'(1);
      end
      if (state == kafq_pkg::ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    case (state)
      kafq_pkg::ST_IDLE: begin
        req_kind    <= s_tuser;
        req_entry   <= s_entry;
        res_entry   <= '0;
        res_valid   <= 1'b0;
        res_evicted <= 1'b0;
        res_dropped <= '0;
        scan_idx    <= '0;
      end
      kafq_pkg::ST_SCAN: begin
        if (scan_hit) begin
          victim <= scan_idx;
        end else if (scan_last) begin
          victim <= '0;   // all keyframes, the front goes
        end
        scan_idx <= scan_idx + IW'(1);
      end
      kafq_pkg::ST_EVICT: begin
        res_evicted <= 1'b1;
      end
      kafq_pkg::ST_DROP: begin
        if (drop_more) begin
          if (res_dropped != '1) begin
            res_dropped <= res_dropped + kafq_pkg::DISC_W'(1);
          end
        end else begin
          res_entry <= cell_data[0];
          res_valid <= 1'b1;
        end
      end
      kafq_pkg::ST_FINISH: begin
        if (out_free) begin
          out_entry   <= res_entry;
          out_valid   <= res_valid && (req_kind == kafq_pkg::REQ_DEQUEUE);
          out_evicted <= res_evicted;
          out_dropped <= res_dropped;
          out_occ     <= occ_now;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tuser = out_valid;
  assign m_tdata = {7'd0, out_occ, out_dropped, out_evicted, out_entry.key,
                    out_entry.ptime, out_entry.number, out_entry.handle};

endmodule

// ===== tb/tb.sv =====
// self-checking bench for keyframe_aware_frame_queue: directed and random requests
// with a queue predictor, random idling on both stream sides and limit changes
// depends on kafq_pkg and the queue rtl
`timescale 1ns / 100ps

module tb;

  localparam int QDEPTH    = kafq_pkg::DEPTH_DEFAULT;
  localparam int EXP_SLOTS = 16;

  typedef struct packed {
    logic                          frame_valid;
    logic [kafq_pkg::HANDLE_W-1:0] handle;
    logic [kafq_pkg::NUMBER_W-1:0] number;
    logic [kafq_pkg::TIME_W-1:0]   ptime;
    logic                          key;
    logic                          evicted;
    logic [kafq_pkg::DISC_W-1:0]   discarded;
    logic [kafq_pkg::OCC_W-1:0]    occupancy;
  } frame_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [kafq_pkg::LIMIT_W-1:0] cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [167:0]                 s_tdata = '0;  // frame_handle, frame_number, presentation_time, key_mark
  logic                         s_tuser = 1'b0; // req_type
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [175:0]                 m_tdata;        // out_handle, out_number, out_time, out_key, evicted,
                                                // discarded_count, occupancy
  logic                         m_tuser;        // frame_valid

  // predictor state
  kafq_pkg::entry_t             held [QDEPTH];
  int                           held_count = 0;
  logic [kafq_pkg::LIMIT_W-1:0] limit_reg = kafq_pkg::LIMIT_RESET;

  // expected results in order, as a small ring
  frame_result_t                exp_ring [EXP_SLOTS];
  int                           exp_head = 0;
  int                           exp_tail = 0;

  int failures = 0;
  bit sender_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  int stall_left = 0;

  keyframe_aware_frame_queue dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int results_outstanding();
    return exp_tail - exp_head;
  endfunction

  function automatic void remove_entry(int pos);
    int i;
    if (pos < held_count) begin
      for (i = pos; i + 1 < held_count; i++) held[i] = held[i + 1];
      held_count--;
    end
  endfunction

  function automatic frame_result_t predict_result(logic req, kafq_pkg::entry_t item);
    frame_result_t r;
    int lim;
    int victim;
    int dropped;
    int i;
    bit found;
    r = '0;
    dropped = 0;
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > QDEPTH) lim = QDEPTH;
    if (req == kafq_pkg::REQ_ENQUEUE) begin
      if (held_count >= lim && held_count > 0) begin
        // oldest non-keyframe goes; with only keyframes the front goes
        victim = 0;
        found = 1'b0;
        for (i = 0; i < held_count; i++) begin
          if (!found && !held[i].key) begin
            victim = i;
            found = 1'b1;
          end
        end
        remove_entry(victim);
        r.evicted = 1'b1;
      end
      if (held_count < QDEPTH) begin
        held[held_count] = item;
        held_count++;
      end
    end else if (held_count > 0) begin
      while (held_count > 1 && !(held[0].key && !held[1].key)) begin
        remove_entry(0);
        dropped++;
      end
      r.frame_valid = 1'b1;
      r.handle = held[0].handle;
      r.number = held[0].number;
      r.ptime = held[0].ptime;
      r.key = held[0].key;
      remove_entry(0);
      r.discarded = (dropped > 7) ? 3'd7 : dropped[kafq_pkg::DISC_W-1:0];
    end
    r.occupancy = (held_count > 15) ? 4'd15 : held_count[kafq_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  // transactions on all three channels, sampled at the rising edge
  always @(posedge clk) begin : monitor
    frame_result_t want;
    kafq_pkg::entry_t item;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (results_outstanding() == 0) begin
          $display("%0t: result with nothing expected, actual %h user %b",
                   $time, m_tdata, m_tuser);
          failures++;
        end else begin
          want = exp_ring[exp_head % EXP_SLOTS];
          exp_head++;
          check_field("frame_valid", 64'(want.frame_valid), 64'(m_tuser));
          check_field("out_handle", 64'(want.handle), 64'(m_tdata[31:0]));
          check_field("out_number", want.number, m_tdata[95:32]);
          check_field("out_time", want.ptime, m_tdata[159:96]);
          check_field("out_key", 64'(want.key), 64'(m_tdata[160]));
          check_field("evicted", 64'(want.evicted), 64'(m_tdata[161]));
          check_field("discarded_count", 64'(want.discarded), 64'(m_tdata[164:162]));
          check_field("occupancy", 64'(want.occupancy), 64'(m_tdata[168:165]));
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (s_tvalid && s_tready) begin
        item = s_tdata[160:0];
        if (results_outstanding() >= EXP_SLOTS) begin
          $display("%0t: too many results outstanding, expected %0d actual %0d",
                   $time, EXP_SLOTS - 1, results_outstanding());
          failures++;
        end
        exp_ring[exp_tail % EXP_SLOTS] = predict_result(s_tuser, item);
        exp_tail++;
      end
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!sink_quiet && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
      stall_left = pick_gap(1'b0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic kafq_pkg::entry_t entry_of(logic [31:0] h, logic [63:0] n,
                                                logic [63:0] t, logic k);
    kafq_pkg::entry_t e;
    e.handle = h;
    e.number = n;
    e.ptime = t;
    e.key = k;
    return e;
  endfunction

  function automatic kafq_pkg::entry_t random_entry(int key_pct);
    return entry_of($urandom, {$urandom, $urandom}, {$urandom, $urandom},
                    $urandom_range(0, 99) < key_pct);
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_request(logic req, kafq_pkg::entry_t e);
    int gap;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {7'b0, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic enqueue(kafq_pkg::entry_t e);
    send_request(kafq_pkg::REQ_ENQUEUE, e);
  endtask

  task automatic dequeue();
    send_request(kafq_pkg::REQ_DEQUEUE, random_entry(50));
  endtask

  // the limit register is only written once the queue has gone idle
  task automatic set_limit(logic [kafq_pkg::LIMIT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (results_outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_and_extremes();
    dequeue();
    enqueue(entry_of('0, '0, '0, 1'b0));
    enqueue(entry_of('1, '1, '1, 1'b1));
    dequeue();
    dequeue();
    dequeue();
  endtask

  task automatic test_keyframe_eviction();
    set_limit(4'd2);
    enqueue(entry_of(32'h1111_0001, 64'd1, 64'd100, 1'b1));
    enqueue(entry_of(32'h1111_0002, 64'd2, 64'd200, 1'b1));
    // every entry a keyframe: the front one makes room
    enqueue(entry_of(32'h1111_0003, 64'd3, 64'd300, 1'b0));
    enqueue(entry_of(32'h1111_0004, 64'd4, 64'd400, 1'b1));
    dequeue();
    dequeue();
  endtask

  task automatic test_limit_floor();
    set_limit(4'd0);
    enqueue(random_entry(50));
    enqueue(random_entry(50));
    dequeue();
  endtask

  task automatic test_lowered_limit();
    set_limit(4'd8);
    repeat (8) enqueue(random_entry(0));
    // a lower limit still only evicts one entry per enqueue
    set_limit(4'd2);
    enqueue(random_entry(0));
    dequeue();
  endtask

  task automatic run_random(int count, int enq_pct, int key_pct);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 63) == 0) sender_quiet = ~sender_quiet;
      if ($urandom_range(0, 63) == 0) sink_quiet = ~sink_quiet;
      if ($urandom_range(0, 99) < enq_pct) enqueue(random_entry(key_pct));
      else dequeue();
    end
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [kafq_pkg::LIMIT_W-1:0] limits [8];
    int key_pcts [4];
    int p;
    limits = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd5, 4'd2, 4'd8};
    key_pcts = '{25, 90, 0, 50};
    limits[7] = 4'($urandom_range(0, 15));
    for (p = 0; p < 8; p++) begin
      set_limit(limits[p]);
      run_random(230, (p % 3 == 0) ? 80 : ((p % 3 == 1) ? 55 : 65), key_pcts[p % 4]);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_and_extremes();
    test_keyframe_eviction();
    test_limit_floor();
    test_lowered_limit();
    test_random_phases();
    s_tvalid <= 1'b0;
    while (results_outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb failed");
    $finish;
  end

endmodule
